// File: hdl/uv_sphere_mesh_generator_defines.svh
// assertion macros for the uv sphere mesh generator
`ifndef UV_SPHERE_MESH_GENERATOR_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SMG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SMG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/smg_pkg.sv
// shared types, constants and tables of the uv sphere mesh generator
`default_nettype none

package smg_pkg;

  localparam int DIV_STEPS    = 32;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [31:0] CORDIC_K30 = 32'sd652032874;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_SECTORS = 2'd1;
  localparam logic [1:0] CFG_STACKS  = 2'd2;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_TRI    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // side data that travels with an item through the cells
  typedef struct packed {
    logic       err;
    logic [6:0] i;
    logic [7:0] j;
    logic [1:0] qs;
    logic [1:0] qc;
  } tag_t;

  // restoring divider state: partial remainder and dividend/quotient word
  typedef struct packed {
    logic [7:0]  r;
    logic [31:0] w;
  } div_t;

  // rotation state
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rot_t;

  // what the result sequencer needs beside the coordinates
  typedef struct packed {
    logic        err;
    logic        up;
    logic        down;
    logic [16:0] k1;
    logic [16:0] k2;
  } meta_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] v;
    unique case (k)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/smg_div_cell.sv
// one bit step of the two phase dividers (stack and sector lanes)
`default_nettype none

module smg_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire smg_pkg::tag_t in_tag,
  input  wire smg_pkg::div_t in_s,
  input  wire smg_pkg::div_t in_c,
  input  wire logic [7:0]    d_s,
  input  wire logic [7:0]    d_c,
  output logic               out_valid,
  output smg_pkg::tag_t      out_tag,
  output smg_pkg::div_t      out_s,
  output smg_pkg::div_t      out_c
);

  // shift in one dividend bit, subtract when it fits
  function automatic smg_pkg::div_t div_step(input smg_pkg::div_t a, input logic [7:0] d);
    logic [8:0]    rr;
    logic          q;
    smg_pkg::div_t b;
    rr = {a.r, a.w[31]};
    q  = (rr >= {1'b0, d});
    if (q) begin
      rr = rr - {1'b0, d};
    end
    b.r = rr[7:0];
    b.w = {a.w[30:0], q};
    return b;
  endfunction

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      out_s   <= div_step(in_s, d_s);
      out_c   <= div_step(in_c, d_c);
    end
  end

endmodule

`default_nettype wire

// File: hdl/smg_cordic_cell.sv
// one rotation step of the two sine/cosine lanes
`default_nettype none

module smg_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire smg_pkg::tag_t in_tag,
  input  wire smg_pkg::rot_t in_s,
  input  wire smg_pkg::rot_t in_c,
  output logic               out_valid,
  output smg_pkg::tag_t      out_tag,
  output smg_pkg::rot_t      out_s,
  output smg_pkg::rot_t      out_c
);

  localparam logic signed [31:0] ATAN = $signed(smg_pkg::atan_turn(STEP));

  // rotate towards zero residual angle
  function automatic smg_pkg::rot_t rot_step(input smg_pkg::rot_t a);
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    smg_pkg::rot_t      b;
    dx = $signed(a.y) >>> STEP;
    dy = $signed(a.x) >>> STEP;
    if (!a.z[31]) begin
      b.x = $signed(a.x) - dx;
      b.y = $signed(a.y) + dy;
      b.z = $signed(a.z) - ATAN;
    end else begin
      b.x = $signed(a.x) + dx;
      b.y = $signed(a.y) - dy;
      b.z = $signed(a.z) + ATAN;
    end
    return b;
  endfunction

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      out_s   <= rot_step(in_s);
      out_c   <= rot_step(in_c);
    end
  end

endmodule

`default_nettype wire

// File: hdl/smg_emit.sv
// output register that sends the vertex and the triangles of one grid point
`default_nettype none

module smg_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire smg_pkg::meta_t     in_meta,
  input  wire logic signed [16:0] in_x,
  input  wire logic signed [16:0] in_y,
  input  wire logic signed [16:0] in_z,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              kind,
  output logic signed [16:0]      value_a,
  output logic signed [16:0]      value_b,
  output logic signed [16:0]      value_c,
  output logic                    last
);

  typedef enum logic [1:0] {
    STEP_VERTEX,
    STEP_UP,
    STEP_DOWN
  } step_t;

  logic               valid;
  smg_pkg::meta_t     meta;
  logic signed [16:0] cx;
  logic signed [16:0] cy;
  logic signed [16:0] cz;
  step_t              step;
  smg_pkg::kind_t     cur_kind;

  // current result from the held item
  always_comb begin
    cur_kind = smg_pkg::KIND_ERROR;
    value_a  = '0;
    value_b  = '0;
    value_c  = '0;
    last     = 1'b1;
    if (!meta.err) begin
      unique case (step)
        STEP_VERTEX: begin
          cur_kind = smg_pkg::KIND_VERTEX;
          value_a  = cx;
          value_b  = cy;
          value_c  = cz;
          last     = !meta.up && !meta.down;
        end
        STEP_UP: begin
          cur_kind = smg_pkg::KIND_TRI;
          value_a  = $signed(meta.k1);
          value_b  = $signed(meta.k2);
          value_c  = $signed(meta.k1 + 17'd1);
          last     = !meta.down;
        end
        STEP_DOWN: begin
          cur_kind = smg_pkg::KIND_TRI;
          value_a  = $signed(meta.k1 + 17'd1);
          value_b  = $signed(meta.k2);
          value_c  = $signed(meta.k2 + 17'd1);
          last     = 1'b1;
        end
        default: begin
          cur_kind = smg_pkg::KIND_ERROR;
        end
      endcase
    end
  end

  assign kind      = cur_kind;
  assign out_valid = valid;
  assign take      = !valid || (out_ready && last);

  // hold an item and walk through its results
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      step  <= STEP_VERTEX;
    end else if (take) begin
      valid <= in_valid;
      step  <= STEP_VERTEX;
    end else if (out_ready) begin
      step <= (step == STEP_VERTEX && meta.up) ? STEP_UP : STEP_DOWN;
    end
  end

  // payload of the held item
  always_ff @(posedge clk) begin
    if (take) begin
      meta <= in_meta;
      cx   <= in_x;
      cy   <= in_y;
      cz   <= in_z;
    end
  end

endmodule

`default_nettype wire

// File: hdl/uv_sphere_mesh_generator.sv
// UV sphere mesh generator: vertex and triangle indices for each grid point
//
// Input channel (in_valid/in_ready) takes one grid point, stack_index and
// sector_index, per item. Output channel (out_valid/out_ready) gives its
// results: the vertex first, then up to two triangles, the final one with
// last set. A grid point out of range, or a register out of range, gives a
// single result of kind 2 with zero values.
// From input item to first result an item passes 32 divider cells (phase),
// 30 rotation cells (sine/cosine), 5 scaling stages and the output register.
// One grid point enters per cycle while the chain advances; the output
// register sends one result per cycle while out_ready is high, so a point
// with triangles holds the chain until its last result is taken. When the
// receiver stalls the whole chain of cells holds; the input still takes an
// item while the tail stage is empty. Reset clears all valid bits and sets
// radius 256, 64 sectors, 32 stacks. Registers are to be written by the user
// through cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none

`include "uv_sphere_mesh_generator_defines.svh"

module uv_sphere_mesh_generator #(
  parameter int MAX_SECTORS    = 128,
  parameter int MAX_STACKS     = 64,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [6:0]         stack_index,
  input  wire logic [7:0]         sector_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              kind,
  output logic signed [16:0]      value_a,
  output logic signed [16:0]      value_b,
  output logic signed [16:0]      value_c,
  output logic                    last
);

  localparam int F   = TRIG_FRAC_BITS;
  localparam int TW  = F + 2;          // trig value width
  localparam int PW  = F + 19;         // radius times trig
  localparam int XW  = 26;             // xy in q8
  localparam int MW  = XW + TW;        // xy times trig
  localparam int NS  = smg_pkg::DIV_STEPS;
  localparam int NR  = smg_pkg::CORDIC_STEPS;
  localparam int SH1 = 30 - F;
  localparam int SH2 = F - 8;
  localparam int SH3 = F;
  localparam int SH4 = F + 8;
  localparam logic signed [32:0]   H1    = (33'sd1 <<< SH1) >>> 1;
  localparam logic signed [PW:0]   H2    = ((PW+1)'(1) <<< SH2) >>> 1;
  localparam logic signed [PW:0]   H3    = ((PW+1)'(1) <<< SH3) >>> 1;
  localparam logic signed [MW:0]   H4    = ((MW+1)'(1) <<< SH4) >>> 1;
  localparam logic signed [32:0]   ONE   = 33'sd1 <<< F;

  // configuration registers
  logic [15:0] radius;
  logic [7:0]  sector_count;
  logic [6:0]  stack_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 16'd256;
      sector_count <= 8'd64;
      stack_count  <= 7'd32;
    end else if (cfg_write) begin
      unique case (cfg_index)
        smg_pkg::CFG_RADIUS:  radius       <= cfg_data;
        smg_pkg::CFG_SECTORS: sector_count <= cfg_data[7:0];
        smg_pkg::CFG_STACKS:  stack_count  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic s5_valid;
  logic emit_take;

  // the chain moves unless the tail stage is stuck
  assign adv      = !s5_valid || emit_take;
  assign in_ready = adv;

  // divider chain: phase = round(n * 2^32 / d)
  logic          div_valid [0:NS];
  smg_pkg::tag_t div_tag   [0:NS];
  smg_pkg::div_t div_s     [0:NS];
  smg_pkg::div_t div_c     [0:NS];
  logic [7:0]    d_s;
  logic [7:0]    d_c;

  assign d_s = {stack_count, 1'b0};
  assign d_c = sector_count;

  // entry: range check and starting remainder
  always_comb begin
    div_valid[0]   = in_valid;
    div_tag[0].err = (32'(stack_count) < 2) || (32'(stack_count) > MAX_STACKS) ||
                     (32'(sector_count) < 3) || (32'(sector_count) > MAX_SECTORS) ||
                     (stack_index > stack_count) || (sector_index > sector_count);
    div_tag[0].i   = stack_index;
    div_tag[0].j   = sector_index;
    div_tag[0].qs  = 2'b00;
    div_tag[0].qc  = 2'b00;
    div_s[0].r     = {1'b0, stack_index};
    div_s[0].w     = 32'(d_s >> 1);
    div_c[0].r     = (sector_index == sector_count) ? 8'd0 : sector_index;
    div_c[0].w     = 32'(d_c >> 1);
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    smg_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (div_valid[k]),
      .in_tag    (div_tag[k]),
      .in_s      (div_s[k]),
      .in_c      (div_c[k]),
      .d_s       (d_s),
      .d_c       (d_c),
      .out_valid (div_valid[k+1]),
      .out_tag   (div_tag[k+1]),
      .out_s     (div_s[k+1]),
      .out_c     (div_c[k+1])
    );
  end

  // rotation chain
  logic          rot_valid [0:NR];
  smg_pkg::tag_t rot_tag   [0:NR];
  smg_pkg::rot_t rot_s     [0:NR];
  smg_pkg::rot_t rot_c     [0:NR];

  // quadrant goes with the tag, the rest of the phase into the rotator
  always_comb begin
    rot_valid[0]  = div_valid[NS];
    rot_tag[0]    = div_tag[NS];
    rot_tag[0].qs = div_s[NS].w[31:30];
    rot_tag[0].qc = div_c[NS].w[31:30];
    rot_s[0].x    = smg_pkg::CORDIC_K30;
    rot_s[0].y    = '0;
    rot_s[0].z    = {2'b00, div_s[NS].w[29:0]};
    rot_c[0].x    = smg_pkg::CORDIC_K30;
    rot_c[0].y    = '0;
    rot_c[0].z    = {2'b00, div_c[NS].w[29:0]};
  end

  for (genvar k = 0; k < NR; k++) begin : g_rot
    smg_cordic_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (rot_valid[k]),
      .in_tag    (rot_tag[k]),
      .in_s      (rot_s[k]),
      .in_c      (rot_c[k]),
      .out_valid (rot_valid[k+1]),
      .out_tag   (rot_tag[k+1]),
      .out_s     (rot_s[k+1]),
      .out_c     (rot_c[k+1])
    );
  end

  // round to trig precision and clamp to one
  function automatic logic signed [TW-1:0] trig_q(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = ($signed({v[31], v}) + H1) >>> SH1;
    if (t > ONE) begin
      t = ONE;
    end else if (t < -ONE) begin
      t = -ONE;
    end
    return t[TW-1:0];
  endfunction

  // saturate a coordinate to the output range
  function automatic logic signed [16:0] sat_coord(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (t > 64'sd65535) begin
      t = 64'sd65535;
    end else if (t < -64'sd65535) begin
      t = -64'sd65535;
    end
    return t[16:0];
  endfunction

  // stage 1: quadrant mapping
  logic signed [TW-1:0] sx_s, sy_s, sx_c, sy_c;
  logic signed [TW-1:0] cos_s, sin_s, cos_c, sin_c;

  always_comb begin
    sx_s = trig_q(rot_s[NR].x);
    sy_s = trig_q(rot_s[NR].y);
    sx_c = trig_q(rot_c[NR].x);
    sy_c = trig_q(rot_c[NR].y);
    unique case (rot_tag[NR].qs)
      2'd0:    begin cos_s = sx_s;  sin_s = sy_s;  end
      2'd1:    begin cos_s = -sy_s; sin_s = sx_s;  end
      2'd2:    begin cos_s = -sx_s; sin_s = -sy_s; end
      default: begin cos_s = sy_s;  sin_s = -sx_s; end
    endcase
    unique case (rot_tag[NR].qc)
      2'd0:    begin cos_c = sx_c;  sin_c = sy_c;  end
      2'd1:    begin cos_c = -sy_c; sin_c = sx_c;  end
      2'd2:    begin cos_c = -sx_c; sin_c = -sy_c; end
      default: begin cos_c = sy_c;  sin_c = -sx_c; end
    endcase
  end

  logic                 s1_valid;
  smg_pkg::tag_t        s1_tag;
  logic signed [TW-1:0] s1_cs, s1_ss, s1_ca, s1_sa;

  logic                 s2_valid;
  smg_pkg::meta_t       s2_meta;
  logic signed [PW-1:0] s2_pxy, s2_pz;
  logic signed [TW-1:0] s2_ca, s2_sa;

  logic                 s3_valid;
  smg_pkg::meta_t       s3_meta;
  logic signed [XW-1:0] s3_xy;
  logic signed [16:0]   s3_z;
  logic signed [TW-1:0] s3_ca, s3_sa;

  logic                 s4_valid;
  smg_pkg::meta_t       s4_meta;
  logic signed [MW-1:0] s4_px, s4_py;
  logic signed [16:0]   s4_z;

  smg_pkg::meta_t       s5_meta;
  logic signed [16:0]   s5_x, s5_y, s5_z;

  // triangle flags and indices
  smg_pkg::meta_t meta_in;
  logic           tri_ok;

  always_comb begin
    tri_ok       = (s1_tag.i < stack_count) && (s1_tag.j < sector_count);
    meta_in.err  = s1_tag.err;
    meta_in.up   = tri_ok && (s1_tag.i != 7'd0);
    meta_in.down = tri_ok && (s1_tag.i != stack_count - 7'd1);
    meta_in.k1   = 17'(s1_tag.i) * (17'(sector_count) + 17'd1) + 17'(s1_tag.j);
    meta_in.k2   = 17'(s1_tag.i) * (17'(sector_count) + 17'd1) + 17'(s1_tag.j) +
                   17'(sector_count) + 17'd1;
  end

  // scaling stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= rot_valid[NR];
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // scaling stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // trig values
      s1_tag  <= rot_tag[NR];
      s1_cs   <= cos_s;
      s1_ss   <= sin_s;
      s1_ca   <= cos_c;
      s1_sa   <= sin_c;
      // radius products
      s2_meta <= meta_in;
      s2_pxy  <= $signed({1'b0, radius}) * s1_ss;
      s2_pz   <= $signed({1'b0, radius}) * s1_cs;
      s2_ca   <= s1_ca;
      s2_sa   <= s1_sa;
      // xy in q8 and z
      s3_meta <= s2_meta;
      s3_xy   <= XW'(($signed({s2_pxy[PW-1], s2_pxy}) + H2) >>> SH2);
      s3_z    <= sat_coord(64'(($signed({s2_pz[PW-1], s2_pz}) + H3) >>> SH3));
      s3_ca   <= s2_ca;
      s3_sa   <= s2_sa;
      // xy products
      s4_meta <= s3_meta;
      s4_px   <= s3_xy * s3_ca;
      s4_py   <= s3_xy * s3_sa;
      s4_z    <= s3_z;
      // x and y
      s5_meta <= s4_meta;
      s5_x    <= sat_coord(64'(($signed({s4_px[MW-1], s4_px}) + H4) >>> SH4));
      s5_y    <= sat_coord(64'(($signed({s4_py[MW-1], s4_py}) + H4) >>> SH4));
      s5_z    <= s4_z;
    end
  end

  // result sequencer and output register
  smg_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_meta   (s5_meta),
    .in_x      (s5_x),
    .in_y      (s5_y),
    .in_z      (s5_z),
    .take      (emit_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .value_a   (value_a),
    .value_b   (value_b),
    .value_c   (value_c),
    .last      (last)
  );

  // checks
  `SMG_ASSERT_NOW(a_error_single, out_valid && kind == smg_pkg::KIND_ERROR, last, "error result without last")
  `SMG_ASSERT_NEXT(a_tri_follows, out_valid && out_ready && !last, out_valid && kind == smg_pkg::KIND_TRI, "non-final result not followed by a triangle")
  `SMG_ASSERT_NOW(a_stall_tail, !adv, s5_valid && out_valid, "chain held without a waiting item")

endmodule

`default_nettype wire
